// ===== rtl/prefetch_aware_request_picker_unit_assert.svh =====
// Assertion macros for the prefetch-aware request picker.
`ifndef PREFETCH_AWARE_REQUEST_PICKER_UNIT_ASSERT_SVH
`define PREFETCH_AWARE_REQUEST_PICKER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define PAWRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("request picker check failed");

// Next-cycle implication, checked out of reset.
`define PAWRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("request picker check failed");

`else

`define PAWRP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PAWRP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/pawrp_pkg.sv =====
// Types and constants shared by the request picker modules.
`default_nettype none

package pawrp_pkg;

    localparam int unsigned IDX_W   = 5;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 104;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [STAMP_W-1:0] stamp_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    typedef struct packed {
        idx_t   entry_index;
        logic   request_ready;
        logic   prefetch;
        logic   row_hit;
        stamp_t arrival_time;
        logic   last_entry;
    } entry_t;

    typedef struct packed {
        idx_t chosen_index;
        cnt_t ready_decided_count;
        cnt_t prefetch_decided_count;
        cnt_t age_decided_count;
    } result_t;

    // Which rule settled this cycle's comparison, plus candidate state.
    typedef struct packed {
        logic have_candidate;
        logic ready_bump;
        logic prefetch_bump;
        logic age_bump;
    } pick_status_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        return (v == '1) ? v : v + cnt_t'(1);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pawrp_in_stage.sv =====
// Input register for incoming request entries.
`default_nettype none

module pawrp_in_stage
    import pawrp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [4:0] entry_index, [5] request_ready, [6] row_hit, [38:7] arrival_time,
    // [39] zero
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
    // [0] prefetch
    input  wire logic                 s_axis_tuser,
    input  wire logic                 s_axis_tlast,
    input  wire logic                 advance,
    output logic                      entry_valid,
    output entry_t                    entry
);

    logic   valid_reg;
    entry_t entry_reg;

    assign s_axis_tready = !valid_reg || advance;
    assign entry_valid   = valid_reg;
    assign entry         = entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            entry_reg.entry_index   <= s_axis_tdata[4:0];
            entry_reg.request_ready <= s_axis_tdata[5];
            entry_reg.prefetch      <= s_axis_tuser;
            entry_reg.row_hit       <= s_axis_tdata[6];
            entry_reg.arrival_time  <= s_axis_tdata[38:7];
            entry_reg.last_entry    <= s_axis_tlast;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pawrp_compare.sv =====
// Held candidate, priority compare and decision counters.
`default_nettype none

module pawrp_compare
    import pawrp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   fire,
    input  wire entry_t entry,
    output logic        result_valid,
    output result_t     result,
    output pick_status_t status
);

    logic   have_cand_reg, have_cand_next;
    logic   best_ready_reg, best_ready_next;
    logic   best_act_reg, best_act_next;
    stamp_t best_arrival_reg, best_arrival_next;
    idx_t   best_pos_reg, best_pos_next;
    cnt_t   ready_cnt_reg, ready_cnt_next;
    cnt_t   pf_cnt_reg, pf_cnt_next;
    cnt_t   age_cnt_reg, age_cnt_next;

    logic act;
    logic take_new;
    logic ready_bump;
    logic pf_bump;
    logic age_bump;

    // An activating prefetch is a prefetch that misses the open row.
    assign act = entry.prefetch && !entry.row_hit;

    always_comb
    begin
        take_new   = 1'b1;
        ready_bump = 1'b0;
        pf_bump    = 1'b0;
        age_bump   = 1'b0;
        if (have_cand_reg)
        begin
            if (best_ready_reg != entry.request_ready)
            begin
                ready_bump = 1'b1;
                take_new   = entry.request_ready;
            end
            else if (best_act_reg != act)
            begin
                pf_bump  = 1'b1;
                take_new = !act;
            end
            else
            begin
                age_bump = 1'b1;
                take_new = entry.arrival_time < best_arrival_reg;
            end
        end
    end

    always_comb
    begin
        have_cand_next    = have_cand_reg;
        best_ready_next   = best_ready_reg;
        best_act_next     = best_act_reg;
        best_arrival_next = best_arrival_reg;
        best_pos_next     = best_pos_reg;
        ready_cnt_next    = ready_cnt_reg;
        pf_cnt_next       = pf_cnt_reg;
        age_cnt_next      = age_cnt_reg;
        if (fire)
        begin
            if (ready_bump)
            begin
                ready_cnt_next = sat_inc(ready_cnt_reg);
            end
            if (pf_bump)
            begin
                pf_cnt_next = sat_inc(pf_cnt_reg);
            end
            if (age_bump)
            begin
                age_cnt_next = sat_inc(age_cnt_reg);
            end
            if (take_new)
            begin
                best_ready_next   = entry.request_ready;
                best_act_next     = act;
                best_arrival_next = entry.arrival_time;
                best_pos_next     = entry.entry_index;
            end
            // Drop the candidate once the round closes.
            have_cand_next = !entry.last_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_cand_reg    <= 1'b0;
            best_ready_reg   <= 1'b0;
            best_act_reg     <= 1'b0;
            best_arrival_reg <= '0;
            best_pos_reg     <= '0;
            ready_cnt_reg    <= '0;
            pf_cnt_reg       <= '0;
            age_cnt_reg      <= '0;
        end
        else
        begin
            have_cand_reg    <= have_cand_next;
            best_ready_reg   <= best_ready_next;
            best_act_reg     <= best_act_next;
            best_arrival_reg <= best_arrival_next;
            best_pos_reg     <= best_pos_next;
            ready_cnt_reg    <= ready_cnt_next;
            pf_cnt_reg       <= pf_cnt_next;
            age_cnt_reg      <= age_cnt_next;
        end
    end

    assign result_valid                  = fire && entry.last_entry;
    assign result.chosen_index           = best_pos_next;
    assign result.ready_decided_count    = ready_cnt_next;
    assign result.prefetch_decided_count = pf_cnt_next;
    assign result.age_decided_count      = age_cnt_next;

    assign status.have_candidate = have_cand_reg;
    assign status.ready_bump     = fire && ready_bump;
    assign status.prefetch_bump  = fire && pf_bump;
    assign status.age_bump       = fire && age_bump;

endmodule

`default_nettype wire

// ===== rtl/pawrp_out_stage.sv =====
// Result register for the chosen request.
`default_nettype none

module pawrp_out_stage
    import pawrp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire result_t               result,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [4:0] chosen_index, [36:5] ready_decided_count,
    // [68:37] prefetch_decided_count, [100:69] age_decided_count, [103:101] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    logic    valid_reg;
    result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {3'b000,
                            result_reg.age_decided_count,
                            result_reg.prefetch_decided_count,
                            result_reg.ready_decided_count,
                            result_reg.chosen_index};

endmodule

`default_nettype wire

// ===== rtl/prefetch_aware_request_picker_unit.sv =====
// The round's last entry is registered in the input stage, then the winner is loaded
// into the result register; the compare runs between the input and the result register.
// Throughput: one entry per cycle; the compare against the held candidate is
// a single registered pass, and only a stalled, still-full result register holds a last entry.
// Reset: asynchronous, active low; clears the candidate, the three decision
// counters and both valid flags.
`default_nettype none

`include "prefetch_aware_request_picker_unit_assert.svh"

module prefetch_aware_request_picker_unit
    import pawrp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [4:0] entry_index, [5] request_ready, [6] row_hit, [38:7] arrival_time,
    // [39] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] prefetch
    input  wire logic                  s_axis_tuser,
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [4:0] chosen_index, [36:5] ready_decided_count,
    // [68:37] prefetch_decided_count, [100:69] age_decided_count, [103:101] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    logic         entry_valid;
    entry_t       entry;
    logic         advance;
    logic         fire;
    logic         result_valid;
    result_t      result;
    pick_status_t status;

    // Hold a last entry only while the result register is full and stalled.
    assign advance = !entry_valid || !entry.last_entry || !m_axis_tvalid || m_axis_tready;
    assign fire    = entry_valid && advance;

    pawrp_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .advance       (advance),
        .entry_valid   (entry_valid),
        .entry         (entry)
    );

    pawrp_compare u_cmp (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .entry        (entry),
        .result_valid (result_valid),
        .result       (result),
        .status       (status)
    );

    pawrp_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (result_valid),
        .result        (result),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    `PAWRP_ASSERT_NOW(a_one_rule, clk, rst_n, 1'b1,
        $onehot0({status.ready_bump, status.prefetch_bump, status.age_bump}))
    `PAWRP_ASSERT_NOW(a_first_no_bump, clk, rst_n, !status.have_candidate,
        !status.ready_bump && !status.prefetch_bump && !status.age_bump)
    `PAWRP_ASSERT_NEXT(a_round_closes, clk, rst_n, fire && entry.last_entry,
        !status.have_candidate && m_axis_tvalid)
    `PAWRP_ASSERT_NEXT(a_no_spurious, clk, rst_n,
        !m_axis_tvalid && !(fire && entry.last_entry), !m_axis_tvalid)

endmodule

`default_nettype wire
